/* src/first_fit_arena_allocator_macros.svh */
// ---------------------------------------------------------------------------
// first_fit_arena_allocator assertion macros
// Concurrent assertion wrappers used by the allocator sequencer, ffa_ctrl.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_ARENA_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_ARENA_ALLOCATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define FFA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FFA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define FFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* src/ffa_pkg.sv */
// ---------------------------------------------------------------------------
// ffa_pkg
// Shared constants, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package ffa_pkg;

    localparam int ARENA_GRANULES_DEF = 4096;
    localparam int GRAN_BYTES = 16;
    localparam int REQ_W = 16;
    localparam int OFF_W = 16;
    localparam int USED_OUT_W = 17;
    localparam int CNT_W = 32;
    localparam int STATUS_W = 3;

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE = 2'd1;
    localparam logic [1:0] MODE_RESET = 2'd2;

    localparam logic [STATUS_W-1:0] RS_GRANTED = 3'd0;
    localparam logic [STATUS_W-1:0] RS_FAILED = 3'd1;
    localparam logic [STATUS_W-1:0] RS_NULL = 3'd2;
    localparam logic [STATUS_W-1:0] RS_UNMATCHED = 3'd3;
    localparam logic [STATUS_W-1:0] RS_DONE = 3'd4;

    localparam int MK_FREE_BIT = 0;
    localparam int MK_START_BIT = 1;
    localparam logic [1:0] MK_NONE = 2'b00;
    localparam logic [1:0] MK_USED = 2'b10;
    localparam logic [1:0] MK_FREE = 2'b11;

    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NOP = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD = 5'd1;
    localparam logic [OP_W-1:0] OP_CLR_STEP = 5'd2;
    localparam logic [OP_W-1:0] OP_WALK_RD = 5'd3;
    localparam logic [OP_W-1:0] OP_WALK_NEXT = 5'd4;
    localparam logic [OP_W-1:0] OP_SPLIT_A = 5'd5;
    localparam logic [OP_W-1:0] OP_SPLIT_B = 5'd6;
    localparam logic [OP_W-1:0] OP_ALLOC_FIN = 5'd7;
    localparam logic [OP_W-1:0] OP_ALLOC_FAIL = 5'd8;
    localparam logic [OP_W-1:0] OP_FREE_RD = 5'd9;
    localparam logic [OP_W-1:0] OP_FREE_BAD = 5'd10;
    localparam logic [OP_W-1:0] OP_FREE_MARK = 5'd11;
    localparam logic [OP_W-1:0] OP_NX_RD = 5'd12;
    localparam logic [OP_W-1:0] OP_NX_MERGE = 5'd13;
    localparam logic [OP_W-1:0] OP_PV_RD = 5'd14;
    localparam logic [OP_W-1:0] OP_PV_MERGE = 5'd15;
    localparam logic [OP_W-1:0] OP_FREE_OK = 5'd16;
    localparam logic [OP_W-1:0] OP_IGNORE = 5'd17;
    localparam logic [OP_W-1:0] OP_ARENA_RST = 5'd18;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            emit;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       is_null;
        logic       off_bad;
        logic       hit;
        logic       split;
        logic       walk_end;
        logic       blk_ok;
        logic       rd_free;
        logic       rd_next_ok;
        logic       prev_ok;
        logic       clr_last;
    } t_sts;

endpackage

/* src/ffa_ctrl.sv */
// ---------------------------------------------------------------------------
// ffa_ctrl
// Sequencer for allocate, free and arena reset, plus the output valid flag.
// ---------------------------------------------------------------------------
`include "first_fit_arena_allocator_macros.svh"

module ffa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  ffa_pkg::t_sts i_sts,
    output ffa_pkg::t_cmd o_cmd
);
    import ffa_pkg::*;

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_DISPATCH = 5'd2;
    localparam logic [4:0] S_WALK_RD = 5'd3;
    localparam logic [4:0] S_WALK_EV = 5'd4;
    localparam logic [4:0] S_SPLIT_A = 5'd5;
    localparam logic [4:0] S_SPLIT_B = 5'd6;
    localparam logic [4:0] S_ALLOC_FIN = 5'd7;
    localparam logic [4:0] S_ALLOC_FAIL = 5'd8;
    localparam logic [4:0] S_FREE_RD = 5'd9;
    localparam logic [4:0] S_FREE_EV = 5'd10;
    localparam logic [4:0] S_FREE_BAD = 5'd11;
    localparam logic [4:0] S_NX_RD = 5'd12;
    localparam logic [4:0] S_NX_EV = 5'd13;
    localparam logic [4:0] S_PV_CHK = 5'd14;
    localparam logic [4:0] S_PV_RD = 5'd15;
    localparam logic [4:0] S_PV_EV = 5'd16;
    localparam logic [4:0] S_FREE_OK = 5'd17;
    localparam logic [4:0] S_IGNORE = 5'd18;
    localparam logic [4:0] S_ARENA_RST = 5'd19;

    logic [4:0] r_state;
    logic [4:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;
    t_cmd       cmd;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        cmd.op = OP_NOP;
        cmd.emit = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                cmd.op = OP_CLR_STEP;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.op = OP_LOAD;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                priority if (i_sts.mode == MODE_ALLOC) begin
                    n_state = S_WALK_RD;
                end else if (i_sts.mode == MODE_FREE && i_sts.is_null) begin
                    n_state = S_IGNORE;
                end else if (i_sts.mode == MODE_FREE && i_sts.off_bad) begin
                    n_state = S_FREE_BAD;
                end else if (i_sts.mode == MODE_FREE) begin
                    n_state = S_FREE_RD;
                end else if (i_sts.mode == MODE_RESET) begin
                    n_state = S_ARENA_RST;
                end else begin
                    n_state = S_IGNORE;
                end
            end
            S_WALK_RD: begin
                cmd.op = OP_WALK_RD;
                n_state = S_WALK_EV;
            end
            S_WALK_EV: begin
                priority if (i_sts.hit) begin
                    n_state = i_sts.split ? S_SPLIT_A : S_ALLOC_FIN;
                end else if (i_sts.walk_end) begin
                    n_state = S_ALLOC_FAIL;
                end else begin
                    cmd.op = OP_WALK_NEXT;
                    n_state = S_WALK_RD;
                end
            end
            S_SPLIT_A: begin
                cmd.op = OP_SPLIT_A;
                n_state = S_SPLIT_B;
            end
            S_SPLIT_B: begin
                cmd.op = OP_SPLIT_B;
                n_state = S_ALLOC_FIN;
            end
            S_ALLOC_FIN: begin
                if (out_free) begin
                    cmd.op = OP_ALLOC_FIN;
                    cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_ALLOC_FAIL: begin
                if (out_free) begin
                    cmd.op = OP_ALLOC_FAIL;
                    cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FREE_RD: begin
                cmd.op = OP_FREE_RD;
                n_state = S_FREE_EV;
            end
            S_FREE_EV: begin
                if (!i_sts.blk_ok) begin
                    n_state = S_FREE_BAD;
                end else begin
                    cmd.op = OP_FREE_MARK;
                    n_state = i_sts.rd_next_ok ? S_NX_RD : S_PV_CHK;
                end
            end
            S_FREE_BAD: begin
                if (out_free) begin
                    cmd.op = OP_FREE_BAD;
                    cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_NX_RD: begin
                cmd.op = OP_NX_RD;
                n_state = S_NX_EV;
            end
            S_NX_EV: begin
                if (i_sts.rd_free) begin
                    cmd.op = OP_NX_MERGE;
                end
                n_state = S_PV_CHK;
            end
            S_PV_CHK: begin
                n_state = i_sts.prev_ok ? S_PV_RD : S_FREE_OK;
            end
            S_PV_RD: begin
                cmd.op = OP_PV_RD;
                n_state = S_PV_EV;
            end
            S_PV_EV: begin
                if (i_sts.rd_free) begin
                    cmd.op = OP_PV_MERGE;
                end
                n_state = S_FREE_OK;
            end
            S_FREE_OK: begin
                if (out_free) begin
                    cmd.op = OP_FREE_OK;
                    cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_IGNORE: begin
                if (out_free) begin
                    cmd.op = OP_IGNORE;
                    cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_ARENA_RST: begin
                if (out_free) begin
                    cmd.op = OP_ARENA_RST;
                    cmd.emit = 1'b1;
                    n_state = S_CLEAR;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd = cmd;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `FFA_ASSERT_IMPLY(a_emit_slot_free, i_clk, i_rst_n, cmd.emit,
        !(r_out_valid && i_out_stall), "result emitted over a stalled result")
    `FFA_ASSERT_IMPLY(a_no_emit_in_clear, i_clk, i_rst_n, r_state == S_CLEAR,
        !cmd.emit, "result emitted during clearing pass")
    `FFA_ASSERT_NEXT(a_reset_then_clear, i_clk, i_rst_n,
        (r_state == S_ARENA_RST) && cmd.emit, r_state == S_CLEAR,
        "arena reset not followed by clearing pass")
    `FFA_ASSERT_NEXT(a_walk_eval, i_clk, i_rst_n, r_state == S_WALK_RD,
        r_state == S_WALK_EV, "walk read not followed by evaluation")

endmodule

/* src/ffa_datapath.sv */
// ---------------------------------------------------------------------------
// ffa_datapath
// Block header memories, walk and free registers, counters and result register.
// ---------------------------------------------------------------------------
module ffa_datapath #(
    parameter int ARENA_GRANULES = ffa_pkg::ARENA_GRANULES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ffa_pkg::t_cmd                     i_cmd,
    output ffa_pkg::t_sts                     o_sts,
    input  logic [1:0]                        i_mode,
    input  logic [ffa_pkg::REQ_W-1:0]         i_request_bytes,
    input  logic [ffa_pkg::OFF_W-1:0]         i_release_offset,
    input  logic                              i_release_null,
    output logic [ffa_pkg::STATUS_W-1:0]      o_status,
    output logic [ffa_pkg::OFF_W-1:0]         o_grant_offset,
    output logic [ffa_pkg::USED_OUT_W-1:0]    o_used_bytes,
    output logic [ffa_pkg::USED_OUT_W-1:0]    o_peak_bytes,
    output logic [ffa_pkg::CNT_W-1:0]         o_alloc_total,
    output logic [ffa_pkg::REQ_W-1:0]         o_largest_request,
    output logic [ffa_pkg::REQ_W-1:0]         o_failed_request,
    output logic [ffa_pkg::CNT_W-1:0]         o_free_total,
    output logic [ffa_pkg::CNT_W-1:0]         o_free_matched,
    output logic [ffa_pkg::CNT_W-1:0]         o_free_unmatched
);
    import ffa_pkg::*;

    localparam int GW = (ARENA_GRANULES > 1) ? $clog2(ARENA_GRANULES) : 1;
    localparam int LW = $clog2(ARENA_GRANULES + 1);
    localparam int SIZE_W = $clog2(ARENA_GRANULES * GRAN_BYTES);
    localparam int USED_W = SIZE_W + 1;
    localparam int AW = ((SIZE_W > REQ_W) ? SIZE_W : REQ_W) + 2;
    localparam logic [LW-1:0] LINK_NONE = LW'(ARENA_GRANULES);
    localparam logic [SIZE_W-1:0] CAP_M16 = SIZE_W'(ARENA_GRANULES * GRAN_BYTES - GRAN_BYTES);
    localparam logic [AW-1:0] CAP_A = AW'(ARENA_GRANULES * GRAN_BYTES);
    localparam logic [AW-1:0] GRAN_A = AW'(GRAN_BYTES);
    localparam logic [SIZE_W-1:0] GRAN_S = SIZE_W'(GRAN_BYTES);

    logic [SIZE_W-1:0] m_size [ARENA_GRANULES];
    logic [LW-1:0]     m_next [ARENA_GRANULES];
    logic [LW-1:0]     m_prev [ARENA_GRANULES];
    logic [1:0]        m_mark [ARENA_GRANULES];

    logic [SIZE_W-1:0] r_rd_size;
    logic [LW-1:0]     r_rd_next;
    logic [LW-1:0]     r_rd_prev;
    logic [1:0]        r_rd_mark;

    logic [1:0]        r_mode;
    logic [REQ_W-1:0]  r_req;
    logic [OFF_W-1:0]  r_off;
    logic              r_null;
    logic [LW-1:0]     r_cur;
    logic [GW-1:0]     r_steps;
    logic [GW-1:0]     r_clr;
    logic [SIZE_W-1:0] r_g_size;
    logic [LW-1:0]     r_g_next;
    logic [LW-1:0]     r_g_prev;

    logic [USED_W-1:0] r_used, n_used;
    logic [USED_W-1:0] r_peak, n_peak;
    logic [CNT_W-1:0]  r_alloc, n_alloc;
    logic [REQ_W-1:0]  r_largest, n_largest;
    logic [REQ_W-1:0]  r_failed, n_failed;
    logic [CNT_W-1:0]  r_free_cnt, n_free_cnt;
    logic [CNT_W-1:0]  r_matched, n_matched;
    logic [CNT_W-1:0]  r_unmatched, n_unmatched;

    logic [STATUS_W-1:0]   r_out_status;
    logic [OFF_W-1:0]      r_out_grant;
    logic [USED_OUT_W-1:0] r_out_used;
    logic [USED_OUT_W-1:0] r_out_peak;
    logic [CNT_W-1:0]      r_out_alloc;
    logic [REQ_W-1:0]      r_out_largest;
    logic [REQ_W-1:0]      r_out_failed;
    logic [CNT_W-1:0]      r_out_free_cnt;
    logic [CNT_W-1:0]      r_out_matched;
    logic [CNT_W-1:0]      r_out_unmatched;

    logic [REQ_W-1:0]  req_one;
    logic [AW-1:0]     req_round;
    logic [AW-1:0]     aligned;
    logic [AW-1:0]     rd_size_a;
    logic [AW-1:0]     sp_a;
    logic [LW-1:0]     sp_link;
    logic [AW-1:0]     off_a;
    logic [GW-1:0]     g_idx;
    logic [LW-1:0]     g_link;
    logic              split;
    logic [SIZE_W-1:0] grant_size;
    logic [SIZE_W-1:0] merge_size;
    logic [LW:0]       cur_p1;
    logic [OFF_W-1:0]  grant;
    logic [STATUS_W-1:0] emit_status;

    logic              rd_en;
    logic [GW-1:0]     rd_addr;
    logic              size_we, next_we, prev_we, mark_we;
    logic [GW-1:0]     size_wa, next_wa, prev_wa, mark_wa;
    logic [SIZE_W-1:0] size_wd;
    logic [LW-1:0]     next_wd, prev_wd;
    logic [1:0]        mark_wd;

    assign req_one = (r_req == '0) ? REQ_W'(1) : r_req;
    assign req_round = AW'(req_one) + AW'(GRAN_BYTES - 1);
    assign aligned = {req_round[AW-1:4], 4'b0000};
    assign rd_size_a = AW'(r_rd_size);
    assign sp_a = AW'(r_cur) + AW'(1) + (aligned >> 4);
    assign sp_link = LW'(sp_a);
    assign split = (rd_size_a >= aligned + (GRAN_A << 1)) && (sp_a < AW'(ARENA_GRANULES));
    assign grant_size = split ? SIZE_W'(aligned) : r_rd_size;
    assign off_a = AW'(r_off);
    assign g_idx = GW'((off_a >> 4) - AW'(1));
    assign g_link = LW'(g_idx);
    assign merge_size = r_g_size + r_rd_size + GRAN_S;
    assign cur_p1 = (LW + 1)'(r_cur) + (LW + 1)'(1);
    assign grant = OFF_W'({cur_p1, 4'b0000});

    always_comb begin
        o_sts.mode = r_mode;
        o_sts.is_null = r_null;
        o_sts.off_bad = (off_a < GRAN_A) || (off_a >= CAP_A) || (r_off[3:0] != 4'd0);
        o_sts.hit = r_rd_mark[MK_FREE_BIT] && (rd_size_a >= aligned);
        o_sts.split = split;
        o_sts.walk_end = (r_rd_next >= LINK_NONE) || (r_steps == GW'(ARENA_GRANULES - 1));
        o_sts.blk_ok = r_rd_mark[MK_START_BIT] && !r_rd_mark[MK_FREE_BIT];
        o_sts.rd_free = r_rd_mark[MK_FREE_BIT];
        o_sts.rd_next_ok = r_rd_next < LINK_NONE;
        o_sts.prev_ok = r_g_prev < LINK_NONE;
        o_sts.clr_last = r_clr == GW'(ARENA_GRANULES - 1);
    end

    always_comb begin
        rd_en = 1'b0;
        rd_addr = '0;
        unique case (i_cmd.op)
            OP_WALK_RD: begin
                rd_en = 1'b1;
                rd_addr = r_cur[GW-1:0];
            end
            OP_FREE_RD: begin
                rd_en = 1'b1;
                rd_addr = g_idx;
            end
            OP_NX_RD: begin
                rd_en = 1'b1;
                rd_addr = r_g_next[GW-1:0];
            end
            OP_PV_RD: begin
                rd_en = 1'b1;
                rd_addr = r_g_prev[GW-1:0];
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        size_we = 1'b0;
        next_we = 1'b0;
        prev_we = 1'b0;
        mark_we = 1'b0;
        size_wa = '0;
        next_wa = '0;
        prev_wa = '0;
        mark_wa = '0;
        size_wd = '0;
        next_wd = '0;
        prev_wd = '0;
        mark_wd = MK_NONE;
        unique case (i_cmd.op)
            OP_CLR_STEP: begin
                mark_we = 1'b1;
                mark_wa = r_clr;
                mark_wd = (r_clr == '0) ? MK_FREE : MK_NONE;
                size_we = (r_clr == '0);
                next_we = (r_clr == '0);
                prev_we = (r_clr == '0);
                size_wd = CAP_M16;
                next_wd = LINK_NONE;
                prev_wd = LINK_NONE;
            end
            OP_SPLIT_A: begin
                size_we = 1'b1;
                next_we = 1'b1;
                prev_we = 1'b1;
                mark_we = 1'b1;
                size_wa = sp_link[GW-1:0];
                next_wa = sp_link[GW-1:0];
                prev_wa = sp_link[GW-1:0];
                mark_wa = sp_link[GW-1:0];
                size_wd = SIZE_W'(rd_size_a - aligned - GRAN_A);
                next_wd = r_rd_next;
                prev_wd = r_cur;
                mark_wd = MK_FREE;
            end
            OP_SPLIT_B: begin
                prev_we = r_rd_next < LINK_NONE;
                prev_wa = r_rd_next[GW-1:0];
                prev_wd = sp_link;
                next_we = 1'b1;
                next_wa = r_cur[GW-1:0];
                next_wd = sp_link;
                size_we = 1'b1;
                size_wa = r_cur[GW-1:0];
                size_wd = SIZE_W'(aligned);
            end
            OP_ALLOC_FIN: begin
                mark_we = 1'b1;
                mark_wa = r_cur[GW-1:0];
                mark_wd = MK_USED;
            end
            OP_FREE_MARK: begin
                mark_we = 1'b1;
                mark_wa = g_idx;
                mark_wd = MK_FREE;
            end
            OP_NX_MERGE: begin
                size_we = 1'b1;
                size_wa = g_idx;
                size_wd = merge_size;
                next_we = 1'b1;
                next_wa = g_idx;
                next_wd = r_rd_next;
                prev_we = r_rd_next < LINK_NONE;
                prev_wa = r_rd_next[GW-1:0];
                prev_wd = g_link;
                mark_we = 1'b1;
                mark_wa = r_g_next[GW-1:0];
                mark_wd = MK_NONE;
            end
            OP_PV_MERGE: begin
                size_we = 1'b1;
                size_wa = r_g_prev[GW-1:0];
                size_wd = merge_size;
                next_we = 1'b1;
                next_wa = r_g_prev[GW-1:0];
                next_wd = r_g_next;
                prev_we = r_g_next < LINK_NONE;
                prev_wa = r_g_next[GW-1:0];
                prev_wd = r_g_prev;
                mark_we = 1'b1;
                mark_wa = g_idx;
                mark_wd = MK_NONE;
            end
            default: begin
                mark_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (size_we) begin
            m_size[size_wa] <= size_wd;
        end
        if (next_we) begin
            m_next[next_wa] <= next_wd;
        end
        if (prev_we) begin
            m_prev[prev_wa] <= prev_wd;
        end
        if (mark_we) begin
            m_mark[mark_wa] <= mark_wd;
        end
        if (rd_en) begin
            r_rd_size <= m_size[rd_addr];
            r_rd_next <= m_next[rd_addr];
            r_rd_prev <= m_prev[rd_addr];
            r_rd_mark <= m_mark[rd_addr];
        end
    end

    always_comb begin
        n_used = r_used;
        n_peak = r_peak;
        n_alloc = r_alloc;
        n_largest = r_largest;
        n_failed = r_failed;
        n_free_cnt = r_free_cnt;
        n_matched = r_matched;
        n_unmatched = r_unmatched;
        emit_status = RS_NULL;
        unique case (i_cmd.op)
            OP_ALLOC_FIN: begin
                n_used = r_used + USED_W'(grant_size);
                n_peak = (n_used > r_peak) ? n_used : r_peak;
                n_alloc = r_alloc + CNT_W'(1);
                n_largest = (req_one > r_largest) ? req_one : r_largest;
                emit_status = RS_GRANTED;
            end
            OP_ALLOC_FAIL: begin
                n_failed = req_one;
                emit_status = RS_FAILED;
            end
            OP_FREE_BAD: begin
                n_free_cnt = r_free_cnt + CNT_W'(1);
                n_unmatched = r_unmatched + CNT_W'(1);
                emit_status = RS_UNMATCHED;
            end
            OP_FREE_MARK: begin
                n_used = r_used - USED_W'(r_rd_size);
            end
            OP_FREE_OK: begin
                n_free_cnt = r_free_cnt + CNT_W'(1);
                n_matched = r_matched + CNT_W'(1);
                emit_status = RS_DONE;
            end
            OP_ARENA_RST: begin
                n_used = '0;
                n_peak = '0;
                n_alloc = '0;
                n_largest = '0;
                n_failed = '0;
                n_free_cnt = '0;
                n_matched = '0;
                n_unmatched = '0;
                emit_status = RS_DONE;
            end
            default: begin
                emit_status = RS_NULL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_peak <= '0;
            r_alloc <= '0;
            r_largest <= '0;
            r_failed <= '0;
            r_free_cnt <= '0;
            r_matched <= '0;
            r_unmatched <= '0;
            r_clr <= '0;
        end else begin
            r_used <= n_used;
            r_peak <= n_peak;
            r_alloc <= n_alloc;
            r_largest <= n_largest;
            r_failed <= n_failed;
            r_free_cnt <= n_free_cnt;
            r_matched <= n_matched;
            r_unmatched <= n_unmatched;
            if (i_cmd.op == OP_CLR_STEP) begin
                r_clr <= r_clr + GW'(1);
            end else if (i_cmd.op == OP_ARENA_RST) begin
                r_clr <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_mode <= i_mode;
            r_req <= i_request_bytes;
            r_off <= i_release_offset;
            r_null <= i_release_null;
            r_cur <= '0;
            r_steps <= '0;
        end
        if (i_cmd.op == OP_WALK_NEXT) begin
            r_cur <= r_rd_next;
            r_steps <= r_steps + GW'(1);
        end
        if (i_cmd.op == OP_FREE_MARK) begin
            r_g_size <= r_rd_size;
            r_g_next <= r_rd_next;
            r_g_prev <= r_rd_prev;
        end
        if (i_cmd.op == OP_NX_MERGE) begin
            r_g_size <= merge_size;
            r_g_next <= r_rd_next;
        end
        if (i_cmd.emit) begin
            r_out_status <= emit_status;
            r_out_grant <= (i_cmd.op == OP_ALLOC_FIN) ? grant : '0;
            r_out_used <= USED_OUT_W'(n_used);
            r_out_peak <= USED_OUT_W'(n_peak);
            r_out_alloc <= n_alloc;
            r_out_largest <= n_largest;
            r_out_failed <= n_failed;
            r_out_free_cnt <= n_free_cnt;
            r_out_matched <= n_matched;
            r_out_unmatched <= n_unmatched;
        end
    end

    assign o_status = r_out_status;
    assign o_grant_offset = r_out_grant;
    assign o_used_bytes = r_out_used;
    assign o_peak_bytes = r_out_peak;
    assign o_alloc_total = r_out_alloc;
    assign o_largest_request = r_out_largest;
    assign o_failed_request = r_out_failed;
    assign o_free_total = r_out_free_cnt;
    assign o_free_matched = r_out_matched;
    assign o_free_unmatched = r_out_unmatched;

endmodule

/* src/first_fit_arena_allocator.sv */
// ---------------------------------------------------------------------------
// first_fit_arena_allocator
// First-fit arena allocator with block splitting and neighbor coalescing.
// ---------------------------------------------------------------------------
// The request channel carries mode, size, freed offset and null flag under
// i_in_valid/o_in_stall; the result channel carries status, grant offset and
// all counters under o_out_valid/i_out_stall. One result per request.
// Requests are handled one at a time. An allocate walks the block headers,
// reading each header from the header memories and then comparing it, and
// then splits the chosen block if needed and finishes. A free with a
// malformed offset answers without a header read; otherwise it reads the
// freed block's header, then does one read per neighbor checked. A null
// free or an unused mode answers without touching the arena. An arena
// reset answers, then runs a clearing pass over the block marks.
// After reset the same clearing pass runs before the first request is
// taken; the counter registers are cleared by reset itself.
// The result sits in an output register. A new request is accepted while a
// result waits; a finished request holds in the sequencer until the
// receiver takes the earlier result.
module first_fit_arena_allocator #(
    parameter int ARENA_GRANULES = ffa_pkg::ARENA_GRANULES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_mode,
    input  logic [ffa_pkg::REQ_W-1:0]         i_request_bytes,
    input  logic [ffa_pkg::OFF_W-1:0]         i_release_offset,
    input  logic                              i_release_null,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ffa_pkg::STATUS_W-1:0]      o_status,
    output logic [ffa_pkg::OFF_W-1:0]         o_grant_offset,
    output logic [ffa_pkg::USED_OUT_W-1:0]    o_used_bytes,
    output logic [ffa_pkg::USED_OUT_W-1:0]    o_peak_bytes,
    output logic [ffa_pkg::CNT_W-1:0]         o_alloc_total,
    output logic [ffa_pkg::REQ_W-1:0]         o_largest_request,
    output logic [ffa_pkg::REQ_W-1:0]         o_failed_request,
    output logic [ffa_pkg::CNT_W-1:0]         o_free_total,
    output logic [ffa_pkg::CNT_W-1:0]         o_free_matched,
    output logic [ffa_pkg::CNT_W-1:0]         o_free_unmatched
);
    import ffa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ffa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ffa_datapath #(
        .ARENA_GRANULES (ARENA_GRANULES)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_mode            (i_mode),
        .i_request_bytes   (i_request_bytes),
        .i_release_offset  (i_release_offset),
        .i_release_null    (i_release_null),
        .o_status          (o_status),
        .o_grant_offset    (o_grant_offset),
        .o_used_bytes      (o_used_bytes),
        .o_peak_bytes      (o_peak_bytes),
        .o_alloc_total     (o_alloc_total),
        .o_largest_request (o_largest_request),
        .o_failed_request  (o_failed_request),
        .o_free_total      (o_free_total),
        .o_free_matched    (o_free_matched),
        .o_free_unmatched  (o_free_unmatched)
    );

endmodule

/* tb/tb_first_fit_arena_allocator.sv */
// ---------------------------------------------------------------------------
// tb_first_fit_arena_allocator
// Self-checking bench for the first-fit arena allocator: a queue of requests
// is driven through the request channel, and every result is compared with a
// software copy of the arena list kept alongside the stimulus.
// ---------------------------------------------------------------------------
module tb_first_fit_arena_allocator;
    import ffa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRANULES = ARENA_GRANULES_DEF;
    localparam int NO_LINK = GRANULES;
    localparam int CAPACITY = GRANULES * GRAN_BYTES;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1000;
    localparam int CALM_TAIL = 100;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef struct {
        logic [1:0]  mode;
        logic [15:0] bytes;
        logic [15:0] offset;
        logic        is_null;
    } t_request;

    typedef struct {
        logic [2:0]  status;
        logic [15:0] grant;
        logic [16:0] used;
        logic [16:0] peak;
        logic [31:0] allocs;
        logic [15:0] largest;
        logic [15:0] failed;
        logic [31:0] frees;
        logic [31:0] matched;
        logic [31:0] unmatched;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_mode;
    logic [15:0] i_request_bytes;
    logic [15:0] i_release_offset;
    logic        i_release_null;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_status;
    logic [15:0] o_grant_offset;
    logic [16:0] o_used_bytes;
    logic [16:0] o_peak_bytes;
    logic [31:0] o_alloc_total;
    logic [15:0] o_largest_request;
    logic [15:0] o_failed_request;
    logic [31:0] o_free_total;
    logic [31:0] o_free_matched;
    logic [31:0] o_free_unmatched;

    first_fit_arena_allocator dut (.*);

    // Shadow arena.
    int unsigned blk_size [GRANULES];
    int unsigned blk_next [GRANULES];
    int unsigned blk_prev [GRANULES];
    bit          blk_free [GRANULES];
    bit          blk_start[GRANULES];
    int unsigned used_sum, peak_sum, largest_req, failed_req;
    logic [31:0] alloc_cnt, free_cnt, matched_cnt, unmatched_cnt;

    t_request    pending_requests[$];
    t_outcome    awaited_results[$];
    int unsigned live_grants[$];
    int          sent_count = 0;
    int          recv_count = 0;
    int          error_count = 0;
    int          idle_cycles = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          hold_off = 0;
    bit          hold_done = 0;
    int          grant_count = 0;
    int          merge_frees = 0;
    int          reject_count = 0;

    function automatic void clear_arena();
        for (int g = 0; g < GRANULES; g++) begin
            blk_size[g] = 0;
            blk_next[g] = 0;
            blk_prev[g] = 0;
            blk_free[g] = 0;
            blk_start[g] = 0;
        end
        blk_size[0] = CAPACITY - GRAN_BYTES;
        blk_next[0] = NO_LINK;
        blk_prev[0] = NO_LINK;
        blk_free[0] = 1;
        blk_start[0] = 1;
        used_sum = 0;
        peak_sum = 0;
        largest_req = 0;
        failed_req = 0;
        alloc_cnt = 0;
        free_cnt = 0;
        matched_cnt = 0;
        unmatched_cnt = 0;
    endfunction

    function automatic logic [2:0] allocate(int unsigned bytes, output int unsigned grant);
        int unsigned size, aligned, cur, steps, sp, nx;
        bit found;
        size = (bytes == 0) ? 1 : bytes;
        aligned = (size + 15) & ~32'd15;
        cur = 0;
        steps = 0;
        found = 0;
        grant = 0;
        while (cur < GRANULES && steps < GRANULES) begin
            if (blk_free[cur] && blk_size[cur] >= aligned) begin
                found = 1;
                break;
            end
            cur = blk_next[cur];
            steps++;
        end
        if (!found) begin
            failed_req = size & 16'hFFFF;
            return RS_FAILED;
        end
        if (blk_size[cur] >= aligned + 2 * GRAN_BYTES) begin
            sp = cur + 1 + aligned / GRAN_BYTES;
            if (sp < GRANULES) begin
                nx = blk_next[cur];
                blk_size[sp] = blk_size[cur] - aligned - GRAN_BYTES;
                blk_next[sp] = nx;
                blk_prev[sp] = cur;
                blk_free[sp] = 1;
                blk_start[sp] = 1;
                if (nx < GRANULES) blk_prev[nx] = sp;
                blk_next[cur] = sp;
                blk_size[cur] = aligned;
            end
        end
        blk_free[cur] = 0;
        used_sum += blk_size[cur];
        if (used_sum > peak_sum) peak_sum = used_sum;
        if (size > largest_req) largest_req = size & 16'hFFFF;
        alloc_cnt++;
        grant = (cur + 1) * GRAN_BYTES;
        return RS_GRANTED;
    endfunction

    function automatic logic [2:0] release_block(int unsigned off);
        int unsigned g, nx, nn, pv;
        free_cnt++;
        if (off < GRAN_BYTES || off >= CAPACITY || (off & 15) != 0) begin
            unmatched_cnt++;
            return RS_UNMATCHED;
        end
        g = off / GRAN_BYTES - 1;
        if (!blk_start[g] || blk_free[g]) begin
            unmatched_cnt++;
            return RS_UNMATCHED;
        end
        blk_free[g] = 1;
        used_sum -= blk_size[g];
        nx = blk_next[g];
        if (nx < GRANULES && blk_free[nx]) begin
            nn = blk_next[nx];
            blk_size[g] += GRAN_BYTES + blk_size[nx];
            blk_next[g] = nn;
            if (nn < GRANULES) blk_prev[nn] = g;
            blk_start[nx] = 0;
            blk_free[nx] = 0;
            merge_frees++;
        end
        pv = blk_prev[g];
        if (pv < GRANULES && blk_free[pv]) begin
            nx = blk_next[g];
            blk_size[pv] += GRAN_BYTES + blk_size[g];
            blk_next[pv] = nx;
            if (nx < GRANULES) blk_prev[nx] = pv;
            blk_start[g] = 0;
            blk_free[g] = 0;
            merge_frees++;
        end
        matched_cnt++;
        return RS_DONE;
    endfunction

    function automatic void add_request(logic [1:0] mode, logic [15:0] bytes,
                                        logic [15:0] offset, logic is_null);
        t_request req;
        t_outcome res;
        int unsigned grant;
        int idx;
        grant = 0;
        req.mode = mode;
        req.bytes = bytes;
        req.offset = offset;
        req.is_null = is_null;
        res.status = RS_NULL;
        case (mode)
            MODE_ALLOC: begin
                res.status = allocate(bytes, grant);
                if (res.status == RS_GRANTED) begin
                    live_grants.push_back(grant);
                    grant_count++;
                end
            end
            MODE_FREE: begin
                if (!is_null) begin
                    res.status = release_block(offset);
                    if (res.status == RS_DONE) begin
                        idx = -1;
                        foreach (live_grants[k]) if (live_grants[k] == offset) idx = k;
                        if (idx >= 0) live_grants.delete(idx);
                    end else begin
                        reject_count++;
                    end
                end
            end
            MODE_RESET: begin
                clear_arena();
                live_grants.delete();
                res.status = RS_DONE;
            end
            default: ;
        endcase
        res.grant = grant[15:0];
        res.used = used_sum[16:0];
        res.peak = peak_sum[16:0];
        res.allocs = alloc_cnt;
        res.largest = largest_req[15:0];
        res.failed = failed_req[15:0];
        res.frees = free_cnt;
        res.matched = matched_cnt;
        res.unmatched = unmatched_cnt;
        pending_requests.push_back(req);
        awaited_results.push_back(res);
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Stimulus and reset.
    initial begin
        int pick, k;
        i_rst_n = 0;
        i_in_valid = 0;
        i_mode = MODE_ALLOC;
        i_request_bytes = 0;
        i_release_offset = 0;
        i_release_null = 0;
        i_out_stall = 0;
        clear_arena();

        add_request(MODE_ALLOC, 16'd0, 16'd0, 1'b0);
        add_request(MODE_ALLOC, 16'd17, 16'd0, 1'b0);
        add_request(MODE_ALLOC, 16'd16, 16'd0, 1'b0);
        add_request(MODE_ALLOC, 16'd1, 16'd0, 1'b0);
        add_request(MODE_FREE, 16'd0, 16'd48, 1'b0);
        add_request(MODE_FREE, 16'd0, 16'd16, 1'b0);
        add_request(MODE_FREE, 16'd0, 16'd96, 1'b0);
        add_request(MODE_FREE, 16'd0, 16'd48, 1'b0);
        add_request(MODE_FREE, 16'd0, 16'd0, 1'b0);
        add_request(MODE_FREE, 16'd0, 16'd17, 1'b0);
        add_request(MODE_FREE, 16'd0, 16'd65535, 1'b0);
        add_request(MODE_FREE, 16'd0, 16'd65520, 1'b0);
        add_request(MODE_FREE, 16'd0, 16'd64, 1'b0);
        add_request(MODE_FREE, 16'hFFFF, 16'hFFFF, 1'b1);
        add_request(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1);
        add_request(MODE_ALLOC, 16'hFFFF, 16'd0, 1'b0);
        add_request(MODE_RESET, 16'd0, 16'd0, 1'b0);
        add_request(MODE_ALLOC, 16'd65520, 16'd0, 1'b0);
        add_request(MODE_ALLOC, 16'd1, 16'd0, 1'b0);
        add_request(MODE_FREE, 16'd0, 16'd16, 1'b0);
        add_request(MODE_ALLOC, 16'd65504, 16'd0, 1'b0);
        add_request(MODE_FREE, 16'd0, 16'd16, 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                if ($urandom_range(0, 19) == 0)
                    add_request(MODE_ALLOC, 16'($urandom), 16'($urandom), 1'b0);
                else
                    add_request(MODE_ALLOC, 16'($urandom_range(0, 400)), 16'($urandom), 1'b0);
            end else if (pick < 85 && live_grants.size() > 0) begin
                k = $urandom_range(0, live_grants.size() - 1);
                add_request(MODE_FREE, 16'($urandom), 16'(live_grants[k]), 1'b0);
            end else if (pick < 92) begin
                add_request(MODE_FREE, 16'($urandom), 16'($urandom), 1'b0);
            end else if (pick < 96) begin
                add_request(MODE_FREE, 16'($urandom), 16'($urandom), 1'b1);
            end else if (pick < 98) begin
                add_request(MODE_UNUSED, 16'($urandom), 16'($urandom), 1'($urandom));
            end else begin
                add_request(MODE_RESET, 16'($urandom), 16'($urandom), 1'($urandom));
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;

        while (sent_count < pending_requests.size() || awaited_results.size() > 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("Drove %0d requests: %0d grants, %0d neighbor merges, %0d rejected frees.",
                 sent_count, grant_count, merge_frees, reject_count);
        $display("Checked %0d results including arena resets and a long receiver hold-off.",
                 recv_count);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Request driver.
    always @(posedge i_clk) begin
        t_request req;
        if (!i_rst_n) begin
            i_in_valid <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) sent_count++;
            if (!(i_in_valid && o_in_stall)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 0;
                end else if (sent_count < pending_requests.size()) begin
                    if (sent_count < pending_requests.size() - CALM_TAIL
                            && $urandom_range(0, 7) == 0) begin
                        send_gap = $urandom_range(1, 19) - 1;
                        i_in_valid <= 0;
                    end else begin
                        req = pending_requests[sent_count];
                        i_in_valid <= 1;
                        i_mode <= req.mode;
                        i_request_bytes <= req.bytes;
                        i_release_offset <= req.offset;
                        i_release_null <= req.is_null;
                    end
                end else begin
                    i_in_valid <= 0;
                end
            end
        end
    end

    // Result monitor and receiver stall.
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                recv_count++;
                if (awaited_results.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    error_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status", want.status, o_status);
                    check_field("grant_offset", want.grant, o_grant_offset);
                    check_field("used_bytes", want.used, o_used_bytes);
                    check_field("peak_bytes", want.peak, o_peak_bytes);
                    check_field("alloc_total", want.allocs, o_alloc_total);
                    check_field("largest_request", want.largest, o_largest_request);
                    check_field("failed_request", want.failed, o_failed_request);
                    check_field("free_total", want.frees, o_free_total);
                    check_field("free_matched", want.matched, o_free_matched);
                    check_field("free_unmatched", want.unmatched, o_free_unmatched);
                end
            end
            if (!hold_done && recv_count >= 150) begin
                hold_done = 1;
                hold_off = HOLD_OFF_CYCLES;
            end
            if (hold_off > 0) begin
                hold_off--;
                i_out_stall <= 1;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_out_stall <= 1;
            end else if (recv_count < pending_requests.size() - CALM_TAIL
                         && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(1, 19) - 1;
                i_out_stall <= 1;
            end else begin
                i_out_stall <= 0;
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d cycles with no handshake.", idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

/* filelist.f */
+incdir+src
src/ffa_pkg.sv
src/ffa_ctrl.sv
src/ffa_datapath.sv
src/first_fit_arena_allocator.sv
tb/tb_first_fit_arena_allocator.sv
